// ===== src/sssd_pkg.sv =====
package sssd_pkg;

    localparam int VALUE_W    = 32;
    localparam int MOD_W      = 11;
    localparam int RES_W      = 10;
    localparam int POS_W      = 17;
    localparam int TBL_DEPTH  = 1024;
    localparam int ADDR_W     = 10;
    localparam int EPOCH_W    = 8;
    localparam int SUM_W      = VALUE_W + 1;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MAG_W      = NUM_DIGITS * DIGIT_W;
    localparam int DCNT_W     = 4;

    localparam logic [MOD_W-1:0]   K_MAX     = MOD_W'(TBL_DEPTH);
    localparam logic [MOD_W-1:0]   K_ONE     = MOD_W'(1);
    localparam logic [POS_W-1:0]   LEN_MAX   = POS_W'(65536);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    // register index, taken from paddr[2]
    localparam logic REG_MODULUS = 1'b0;

    typedef enum logic [2:0] {
        ST_CLR_INIT,
        ST_IDLE,
        ST_CLR_WRAP,
        ST_MAG,
        ST_DIV,
        ST_FIN,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic sum_en;
        logic mag_en;
        logic step_en;
    } mod_ctl_t;

    typedef struct packed {
        logic clr_step;
        logic new_epoch;
        logic rd_en;
        logic wr_en;
    } tbl_req_t;

    typedef struct packed {
        logic               clr_done;
        logic               epoch_wrap;
        logic               hit;
        logic [POS_W-1:0]   hit_pos;
    } tbl_stat_t;

endpackage

// ===== src/subarray_sum_multiple_detector_unit.sv =====
// Subarray sum multiple detector.
// Input channel (in_valid / in_stall): one signed 32-bit element per transfer,
// with start_req marking the first element of a new array. Output channel
// (out_valid / out_stall): one found bit per element, sticky within an array,
// set once some contiguous run of two or more elements sums to a multiple of
// the modulus register (APB, byte address 0; 0 acts as 1, above 1024 as 1024).
// Each element passes through an accept step, a magnitude step, the
// 4-bit-per-cycle remainder loop over the 33-bit prefix sum, a table read
// and a table update; the result is registered at the update step.
// in_stall is high outside the idle state.
// The first-position table is a 1024-entry memory with 8-bit epoch tags; a
// new array only bumps the epoch. After reset, and again at every 255th
// array start, a clearing pass rewrites all 1024 tags with in_stall
// high; configuration writes are taken throughout.
// A result waiting in the output register does not block the next transfer
// in; only the final update cycle holds while out_stall keeps it full.
// Reset sets the modulus to 1 and makes the first element start an array.
module subarray_sum_multiple_detector_unit
    import sssd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // element channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      start_req,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    state_t            state_reg;
    state_t            state_next;
    logic [MOD_W-1:0]  modulus_reg;
    logic [MOD_W-1:0]  k_eff;
    logic [RES_W-1:0]  residue_reg;
    logic [POS_W-1:0]  count_reg;
    logic              found_flag_reg;
    logic [RES_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic              found_out_reg;

    mod_ctl_t          mod_ctl;
    tbl_req_t          tbl_req;
    tbl_stat_t         tbl_stat;
    logic              begin_req;
    logic              do_begin;
    logic              do_update;
    logic [RES_W-1:0]  base_res;
    logic [RES_W-1:0]  new_res;
    logic              mod_done;
    logic              seen;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  enc;
    logic              run_hit;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_comb
    begin
        if (paddr[2] == REG_MODULUS)
            prdata = {{(32 - MOD_W){1'b0}}, modulus_reg};
        else
            prdata = '0;
    end

    always_comb
    begin
        if (modulus_reg == '0)
            k_eff = K_ONE;
        else if (modulus_reg > K_MAX)
            k_eff = K_MAX;
        else
            k_eff = modulus_reg;
    end

    // ---------------- datapath units ----------------
    // in the idle state the count is zero only before the first element after reset
    assign begin_req = start_req || (count_reg == '0);
    assign base_res  = do_begin ? '0 : residue_reg;

    sssd_mod_unit u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mod_ctl),
        .value    (value),
        .base_res (base_res),
        .k        (k_eff),
        .residue  (new_res),
        .done     (mod_done)
    );

    sssd_table u_tbl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_addr (new_res),
        .wr_addr (idx_reg),
        .wr_pos  (enc),
        .stat    (tbl_stat)
    );

    // residue 0 is always seeded at position minus one (stored as 0)
    assign seen      = (idx_reg == '0) || tbl_stat.hit;
    assign first_pos = (idx_reg == '0) ? '0 : tbl_stat.hit_pos;
    assign enc       = count_reg + POS_W'(1);
    assign run_hit   = seen && (enc >= first_pos + POS_W'(2));

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLR_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mod_ctl    = '0;
        tbl_req    = '0;
        do_begin   = 1'b0;
        do_update  = 1'b0;
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLR_INIT:
            begin
                tbl_req.clr_step = 1'b1;
                if (tbl_stat.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mod_ctl.sum_en = 1'b1;
                    state_next     = ST_MAG;
                    if (begin_req)
                    begin
                        do_begin          = 1'b1;
                        tbl_req.new_epoch = 1'b1;
                        // tags are about to wrap: scrub the table first
                        if (tbl_stat.epoch_wrap)
                            state_next = ST_CLR_WRAP;
                    end
                end
            end
            ST_CLR_WRAP:
            begin
                tbl_req.clr_step = 1'b1;
                if (tbl_stat.clr_done)
                    state_next = ST_MAG;
            end
            ST_MAG:
            begin
                mod_ctl.mag_en = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                mod_ctl.step_en = 1'b1;
                if (mod_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                tbl_req.rd_en = 1'b1;
                state_next    = ST_UPD;
            end
            ST_UPD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    do_update      = 1'b1;
                    tbl_req.wr_en  = !seen;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= K_ONE;
            residue_reg    <= '0;
            count_reg      <= '0;
            found_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr[2] == REG_MODULUS))
                modulus_reg <= pwdata[MOD_W-1:0];

            if (do_begin)
            begin
                residue_reg    <= '0;
                count_reg      <= '0;
                found_flag_reg <= 1'b0;
            end
            else if (do_update)
            begin
                residue_reg <= idx_reg;
                if (count_reg < LEN_MAX)
                    count_reg <= enc;
                if (run_hit)
                    found_flag_reg <= 1'b1;
            end

            if (do_update)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_req.rd_en)
            idx_reg <= new_res;
        if (do_update)
            found_out_reg <= found_flag_reg || run_hit;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_out_reg;

endmodule

// ===== src/sssd_mod_unit.sv =====
module sssd_mod_unit
    import sssd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mod_ctl_t                  ctl,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [RES_W-1:0]          base_res,
    input  logic [MOD_W-1:0]          k,
    output logic [RES_W-1:0]          residue,
    output logic                      done
);

    logic signed [SUM_W-1:0] sum_reg;
    logic [MAG_W-1:0]        sh_reg;
    logic [MAG_W-1:0]        sh_next;
    logic                    neg_reg;
    logic [RES_W-1:0]        rem_reg;
    logic [RES_W-1:0]        rem_next;
    logic [DCNT_W-1:0]       cnt_reg;
    logic [SUM_W-1:0]        mag;
    logic [MOD_W-1:0]        t;
    logic [MOD_W-1:0]        fix;

    assign mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // one radix-2 restoring step per bit, DIGIT_W bits per cycle
    always_comb
    begin
        t = MOD_W'(rem_reg);
        for (int i = 0; i < DIGIT_W; i++)
        begin
            t = {t[MOD_W-2:0], sh_reg[MAG_W-1-i]};
            if (t >= k)
                t = t - k;
        end
        rem_next = t[RES_W-1:0];
        sh_next  = sh_reg << DIGIT_W;
    end

    assign done = (cnt_reg == DCNT_W'(NUM_DIGITS - 1));

    // negative sum: residue of magnitude folded back into 0..k-1
    always_comb
    begin
        fix = k - MOD_W'(rem_reg);
        if (neg_reg && (rem_reg != '0))
            residue = fix[RES_W-1:0];
        else
            residue = rem_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
            sum_reg <= SUM_W'(value) + SUM_W'(signed'({1'b0, base_res}));
        if (ctl.mag_en)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            sh_reg  <= MAG_W'(mag);
            rem_reg <= '0;
        end
        else if (ctl.step_en)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctl.mag_en)
            cnt_reg <= '0;
        else if (ctl.step_en)
            cnt_reg <= cnt_reg + DCNT_W'(1);
    end

endmodule

// ===== src/sssd_table.sv =====
module sssd_table
    import sssd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_req_t          req,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [POS_W-1:0]  wr_pos,
    output tbl_stat_t         stat
);

    // entry = {epoch tag, first position}; tag 0 never matches a live epoch
    logic [EPOCH_W+POS_W-1:0] mem [TBL_DEPTH];
    logic [EPOCH_W+POS_W-1:0] rdata_reg;
    logic [EPOCH_W+POS_W-1:0] wdata;
    logic [ADDR_W-1:0]        waddr;
    logic                     we;
    logic [EPOCH_W-1:0]       epoch_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg;

    always_comb
    begin
        if (req.clr_step)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else
        begin
            we    = req.wr_en;
            waddr = wr_addr;
            wdata = {epoch_reg, wr_pos};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (req.rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (req.new_epoch)
                epoch_reg <= (epoch_reg == EPOCH_MAX) ? EPOCH_W'(1) : epoch_reg + EPOCH_W'(1);
            if (req.clr_step)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    assign stat.clr_done   = (clr_cnt_reg == {ADDR_W{1'b1}});
    assign stat.epoch_wrap = (epoch_reg == EPOCH_MAX);
    assign stat.hit        = (rdata_reg[EPOCH_W+POS_W-1:POS_W] == epoch_reg);
    assign stat.hit_pos    = rdata_reg[POS_W-1:0];

endmodule

// ===== sim/subarray_sum_multiple_detector_unit_test.sv =====
`timescale 1ns / 100ps

module subarray_sum_multiple_detector_unit_test
    import sssd_pkg::*;
();

    // Run limit in clock cycles. A correct run needs far fewer:
    // ~1.7K elements plus random sender gaps, receiver stalls, the long
    // holdoff and a clearing pass after reset and every 255 array starts.
    localparam int CYCLE_LIMIT = 500_000;

    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ELEMENTS  = 215;

    // Results to pass before the receiver holds off, and for how long.
    localparam int HOLDOFF_AFTER   = 400;
    localparam int HOLDOFF_CYCLES  = 300;

    localparam logic [2:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};

    // How a row of the directed table is used. For element rows the kind
    // gives the found bit to check: a fixed value, or the predictor's value.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_CLEAR,
        ROW_SET,
        ROW_MODULUS
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] data;   // element value, or modulus for ROW_MODULUS
        logic        start;
    } stim_row_t;

    // Receiver stall behaviors.
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_LIGHT,
        DRAIN_HEAVY,
        DRAIN_PERIODIC
    } drain_mode_t;

    // Directed part. Starts with modulus 1 out of reset, so any two elements
    // qualify; then the largest modulus, modulus 0 (acts as 1), a modulus
    // above the table (saturates), and a modulus change in the middle of an
    // array.
    localparam stim_row_t DIRECTED_ROWS [27] = '{
        // first element after reset opens an array even without start_req
        '{ROW_CLEAR,   32'h7FFF_FFFF, 1'b0},
        '{ROW_SET,     32'h8000_0000, 1'b0},
        '{ROW_CLEAR,   32'h0000_0000, 1'b1},
        '{ROW_SET,     32'h0000_0005, 1'b0},
        '{ROW_MODULUS, 32'd1024,      1'b0},
        // a single element that is a multiple of k does not count
        '{ROW_CLEAR,   32'd1024,      1'b1},
        '{ROW_SET,     32'd1024,      1'b0},
        // negative prefix sums must wrap to a non-negative residue
        '{ROW_CLEAR,   32'hFFFF_FFFF, 1'b1},
        '{ROW_SET,     32'h0000_0001, 1'b0},
        '{ROW_CLEAR,   32'h0000_0007, 1'b1},
        '{ROW_SET,     32'hFFFF_FFF9, 1'b0},
        '{ROW_CLEAR,   32'h8000_0000, 1'b1},
        '{ROW_PREDICT, 32'h7FFF_FFFF, 1'b0},
        '{ROW_PREDICT, 32'h0000_0001, 1'b0},
        '{ROW_MODULUS, 32'd0,         1'b0},
        '{ROW_CLEAR,   32'd9,         1'b1},
        '{ROW_SET,     32'd9,         1'b0},
        '{ROW_MODULUS, 32'd2047,      1'b0},
        // 1023 + 1025 hits residue 0 only when k saturates to 1024
        '{ROW_CLEAR,   32'd1023,      1'b1},
        '{ROW_SET,     32'd1025,      1'b0},
        '{ROW_MODULUS, 32'd5,         1'b0},
        '{ROW_PREDICT, 32'd4,         1'b1},
        // held residue 4 gets re-reduced by the new modulus
        '{ROW_MODULUS, 32'd3,         1'b0},
        '{ROW_PREDICT, 32'd0,         1'b0},
        '{ROW_PREDICT, 32'd2,         1'b0},
        '{ROW_PREDICT, 32'h8000_0000, 1'b1},
        '{ROW_PREDICT, 32'h8000_0000, 1'b0}
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      start_req = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      found;
    logic                      psel      = 1'b0;
    logic                      penable   = 1'b0;
    logic                      pwrite    = 1'b0;
    logic [2:0]                paddr     = '0;
    logic [31:0]               pwdata    = '0;
    logic [31:0]               prdata;
    logic                      pready;

    subarray_sum_multiple_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .start_req (start_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: prefix residue and first-sighting table, own copy.
    // ------------------------------------------------------------------
    logic [MOD_W-1:0] cfg_modulus   = K_ONE;
    logic [RES_W-1:0] prefix_residue = '0;
    logic [POS_W-1:0] first_pos [TBL_DEPTH];
    bit               residue_seen [TBL_DEPTH];
    logic [POS_W-1:0] elem_count    = '0;
    bit               found_sticky  = 1'b0;

    // found bits still owed by the block, oldest first
    bit found_pending [$];

    int  error_count  = 0;
    int  results_seen = 0;
    int  cycle_count  = 0;
    int  burst_left   = 0;

    function automatic int active_modulus(logic [MOD_W-1:0] k);
        if (k == '0)
            return 1;
        if (k > K_MAX)
            return int'(K_MAX);
        return int'(k);
    endfunction

    task automatic advance_prefix_table(input logic signed [VALUE_W-1:0] v,
                                        input bit start, output bit hit);
        int     k;
        longint sum;
        longint r;
        int     idx;
        int     enc;
        // a start request, or the first element after reset, opens an array
        if (start || elem_count == '0)
        begin
            for (int i = 0; i < TBL_DEPTH; i++)
                residue_seen[i] = 1'b0;
            residue_seen[0] = 1'b1;     // residue 0 seeded at position -1
            first_pos[0]    = '0;
            prefix_residue  = '0;
            elem_count      = '0;
            found_sticky    = 1'b0;
        end
        k   = active_modulus(cfg_modulus);
        sum = longint'(prefix_residue) + longint'(v);
        r   = sum % k;
        if (r < 0)
            r += k;
        idx = int'(r);
        enc = int'(elem_count) + 1;
        if (residue_seen[idx])
        begin
            if (enc >= int'(first_pos[idx]) + 2)
                found_sticky = 1'b1;
        end
        else
        begin
            residue_seen[idx] = 1'b1;
            first_pos[idx]    = POS_W'(enc);
        end
        prefix_residue = RES_W'(idx);
        if (elem_count < LEN_MAX)
            elem_count = elem_count + 1'b1;
        hit = found_sticky;
    endtask

    // ------------------------------------------------------------------
    // Sender: one element transfer; bursts of back-to-back transfers with
    // random gaps between bursts.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [31:0] v, input bit start,
                             input row_kind_t how);
        bit hit;
        in_valid  <= 1'b1;
        value     <= v;
        start_req <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transfer taken at this edge
        advance_prefix_table(v, start, hit);
        if (how == ROW_CLEAR)
            found_pending = {found_pending, 1'b0};
        else if (how == ROW_SET)
            found_pending = {found_pending, 1'b1};
        else
            found_pending = {found_pending, hit};
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20))
                @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Modulus writes only go in with the block idle: every found bit owed
    // must have come back first. Each write is read back.
    task automatic reprogram_modulus(input logic [MOD_W-1:0] k);
        in_valid <= 1'b0;
        while (found_pending.size() != 0)
            @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODULUS_ADDR;
        pwdata  <= {(32 - MOD_W)'($urandom), k};    // upper bits are ignored
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cfg_modulus = k;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(k))
        begin
            $display("%0t: modulus readback mismatch, expected %0d, actual %0d",
                     $time, k, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Element values: small values, near-multiples of k, extremes, raw random.
    function automatic logic [31:0] pick_element(int k);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return 32'($urandom_range(0, 40)) - 32'd20;
        if (pick < 60)
            return 32'(k * ($urandom_range(0, 8) - 4) + $urandom_range(0, 2) - 1);
        if (pick < 70)
        begin
            case ($urandom_range(0, 4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h0000_0001;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly short, well-formed arrays (so the table epoch wraps several
    // hundred starts in), with some missing starts and stray mid-array starts.
    task automatic run_random_phase(input int n_items);
        int sent;
        int len;
        int pick;
        bit start;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                len = $urandom_range(1, 3);
            else if (pick < 97)
                len = $urandom_range(4, 24);
            else
                len = $urandom_range(25, 100);
            for (int i = 0; i < len && sent < n_items; i++)
            begin
                if (i == 0)
                    start = ($urandom_range(0, 7) != 0);
                else
                    start = ($urandom_range(0, 63) == 0);
                send_item(pick_element(active_modulus(cfg_modulus)), start, ROW_PREDICT);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking against the oldest owed found bit.
    // ------------------------------------------------------------------
    bit found_want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (found_pending.size() == 0)
            begin
                $display("%0t: result transfer with none owed, expected none, actual found=%0b",
                         $time, found);
                error_count++;
            end
            else
            begin
                found_want = found_pending.pop_front();
                if (found !== found_want)
                begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, found_want, found);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern. Switches between behaviors at random, and
    // once holds off long enough to back the block up into its input.
    // ------------------------------------------------------------------
    drain_mode_t drain_mode   = DRAIN_FREE;
    int          mode_left    = 0;
    int          holdoff_left = 0;
    bit          holdoff_done = 1'b0;

    always @(posedge clk)
    begin
        if (holdoff_left != 0)
        begin
            out_stall <= 1'b1;
            holdoff_left--;
        end
        else if (!holdoff_done && results_seen >= HOLDOFF_AFTER)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                drain_mode = drain_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end
            else
            begin
                mode_left--;
            end
            case (drain_mode)
                DRAIN_FREE:  out_stall <= 1'b0;
                DRAIN_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                DRAIN_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= (mode_left % 7 < 3);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [MOD_W-1:0] phase_modulus;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_MODULUS)
                reprogram_modulus(DIRECTED_ROWS[i].data[MOD_W-1:0]);
            else
                send_item(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].start,
                          DIRECTED_ROWS[i].kind);
        end

        // random phases, one modulus each, extremes included
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       phase_modulus = K_MAX;
                1:       phase_modulus = MOD_W'($urandom_range(2, 16));
                2:       phase_modulus = K_ONE;
                3:       phase_modulus = MOD_W'($urandom_range(17, 1023));
                4:       phase_modulus = '0;
                5:       phase_modulus = MOD_W'($urandom_range(1025, 2047));
                6:       phase_modulus = MOD_W'($urandom_range(2, 64));
                default: phase_modulus = MOD_W'($urandom_range(512, 1024));
            endcase
            reprogram_modulus(phase_modulus);
            run_random_phase(PHASE_ELEMENTS);
        end

        // drain, then keep watching for stray results before the final check
        in_valid <= 1'b0;
        while (found_pending.size() != 0)
            @(posedge clk);
        repeat (30)
            @(posedge clk);
        if (found_pending.size() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, found_pending.size());
            error_count++;
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
